@@ rtl/core/ptc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the pressure/temperature
// compensation core. Depends on nothing; ptc_divider and the top level import it.
`timescale 1ns / 1ps

package ptc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CAL_T  = 2'd0,
    CFG_CAL_PA = 2'd1,
    CFG_CAL_PB = 2'd2,
    CFG_CAL_PC = 2'd3
  } ptc_cfg_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned DEN_W      = 31;

  localparam logic signed [32:0] TFINE_OFFSET = 33'sd128000;
  localparam logic        [20:0] PRESS_BASE   = 21'd1048576;
  localparam logic signed [16:0] PRESS_SCALE  = 17'sd3125;
  localparam logic        [63:0] P1_BIAS      = 64'h0000_8000_0000_0000;

  localparam logic signed [27:0] TC_MAX = 28'sd8388607;
  localparam logic signed [27:0] TC_MIN = -28'sd8388608;

  // Per-item fields that ride along with the pressure datapath.
  typedef struct packed {
    logic signed [23:0] tcent;
    logic signed [31:0] tfine;
    logic               den_ok;
  } ptc_side_t;

  // Partial products of a 64-bit word times a 17-bit signed factor.
  typedef struct packed {
    logic [49:0] lo;
    logic [31:0] hi;
  } ptc_mul16_t;

  // Partial products of the low 64 bits of a 64-bit square.
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
  } ptc_sq_t;

  function automatic ptc_mul16_t mul16_part(input logic [63:0] x,
                                            input logic signed [16:0] c);
    ptc_mul16_t       r;
    logic signed [49:0] pl;
    logic signed [49:0] ph;
    pl   = $signed({1'b0, x[31:0]}) * c;
    ph   = $signed({1'b0, x[63:32]}) * c;
    r.lo = pl;
    r.hi = ph[31:0];
    return r;
  endfunction

  // Low 64 bits of the full product, from its two partial products.
  function automatic logic [63:0] mul16_sum(input ptc_mul16_t p);
    return {{14{p.lo[49]}}, p.lo} + {p.hi, 32'h0};
  endfunction

  function automatic ptc_sq_t sq_part(input logic [63:0] x);
    ptc_sq_t     r;
    logic [63:0] t;
    r.ll = x[31:0] * x[31:0];
    t    = x[31:0] * x[63:32];
    r.lh = t[31:0];
    return r;
  endfunction

  // The cross term appears twice, hence the extra shift by one.
  function automatic logic [63:0] sq_sum(input ptc_sq_t p);
    return p.ll + {p.lh[30:0], 1'b0, 32'h0};
  endfunction

endpackage

@@ rtl/core/ptc_in_if.sv @@
// Input channel of the compensation core: one raw temperature and pressure
// reading per item. Uses no package.
`timescale 1ns / 1ps

interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

@@ rtl/core/ptc_out_if.sv @@
// Output channel of the compensation core: one compensated result per item.
// Uses no package.
`timescale 1ns / 1ps

interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic        [31:0] pressure_q24_8;
  logic               pressure_valid;

  modport source (output valid, temperature_centi, fine_temperature, pressure_q24_8,
                  pressure_valid, input ready);
  modport sink   (input valid, temperature_centi, fine_temperature, pressure_q24_8,
                  pressure_valid, output ready);
endinterface

@@ rtl/core/ptc_divider.sv @@
// Pipelined restoring divider of the compensation core: one quotient bit per
// stage, unsigned magnitudes in, signed quotient out. Depends on ptc_pkg.
`timescale 1ns / 1ps

module ptc_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [63:0]                  num_abs_i,
  input  logic [ptc_pkg::DEN_W-1:0]    den_abs_i,
  input  logic                         neg_i,
  input  ptc_pkg::ptc_side_t           side_i,
  output logic                         valid_o,
  output logic [63:0]                  quot_o,
  output ptc_pkg::ptc_side_t           side_o
);
  import ptc_pkg::*;

  logic [DEN_W-1:0] rem_q [DIV_STEPS];
  logic [63:0]      dq_q  [DIV_STEPS];
  logic [DEN_W-1:0] den_q [DIV_STEPS];
  logic             neg_q [DIV_STEPS];
  ptc_side_t        side_q[DIV_STEPS];
  logic [DIV_STEPS-1:0] v_q;

  // Each stage shifts one dividend bit into the remainder and trial-subtracts.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [63:0]      dq_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             bit_ok;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = num_abs_i;
      assign den_in = den_abs_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial  = {rem_in, dq_in[63]};
    assign diff   = trial - {1'b0, den_in};
    assign bit_ok = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= bit_ok ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dq_q[k]  <= {dq_in[62:0], bit_ok};
        den_q[k] <= den_in;
        if (k == 0) begin
          neg_q[k]  <= neg_i;
          side_q[k] <= side_i;
        end else begin
          neg_q[k]  <= neg_q[k-1];
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[DIV_STEPS-2:0], valid_i};
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign quot_o  = neg_q[DIV_STEPS-1] ? (64'd0 - dq_q[DIV_STEPS-1]) : dq_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

  // A stall freezes every stage.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(v_q)) else $error("divider moved while stalled");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && valid_i |=> v_q[0]) else $error("divider lost an entering item");
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && den_q[0] != '0 |-> rem_q[0] < den_q[0])
    else $error("divider remainder out of range");

endmodule

@@ rtl/core/pressure_temperature_compensation_core.sv @@
// Top level of the barometer integer compensation core: calibration
// registers, temperature path and pressure path. Depends on ptc_pkg,
// ptc_in_if, ptc_out_if and ptc_divider.
//
//   Channel   Direction  Handshake     Payload
//   in_i      in         valid/ready   raw_temperature, raw_pressure
//   out_o     out        valid/ready   temperature_centi, fine_temperature,
//                                      pressure_q24_8, pressure_valid
//   cfg       in         cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// One item enters per cycle while the pipeline advances; each passes through 11
// arithmetic stages, the 64-stage divider (one quotient bit each) and 6 closing stages.
// Reset clears the calibration registers and all valid bits.
// When the output item is not taken, the whole pipeline holds and in_i.ready
// drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module pressure_temperature_compensation_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ptc_in_if.sink                         in_i,
  ptc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ptc_pkg::*;

  logic [47:0]        cal_t_q;
  logic [63:0]        cal_pa_q;
  logic [63:0]        cal_pb_q;
  logic signed [15:0] cal_pc_q;

  // Calibration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pa_q <= '0;
      cal_pb_q <= '0;
      cal_pc_q <= '0;
    end else if (cfg_we_i) begin
      case (ptc_cfg_e'(cfg_idx_i))
        CFG_CAL_T:  cal_t_q  <= cfg_wdata_i[47:0];
        CFG_CAL_PA: cal_pa_q <= cfg_wdata_i;
        CFG_CAL_PB: cal_pb_q <= cfg_wdata_i;
        CFG_CAL_PC: cal_pc_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Coefficient slices.
  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = cal_t_q[15:0];
  assign t2 = cal_t_q[31:16];
  assign t3 = cal_t_q[47:32];
  assign p1 = cal_pa_q[15:0];
  assign p2 = cal_pa_q[31:16];
  assign p3 = cal_pa_q[47:32];
  assign p4 = cal_pa_q[63:48];
  assign p5 = cal_pb_q[15:0];
  assign p6 = cal_pb_q[31:16];
  assign p7 = cal_pb_q[47:32];
  assign p8 = cal_pb_q[63:48];
  assign p9 = cal_pc_q;

  // Global advance: every stage moves unless the output item is stalled.
  logic adv;
  logic out_v_q;
  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  logic [10:0] pre_v_q;
  logic [5:0]  post_v_q;

  // Stage 1: temperature differences and their products.
  logic signed [17:0] tdiff;
  logic signed [16:0] dsub;
  logic signed [33:0] s1_ta_q, s1_dd_q;
  logic        [20:0] pr_q [1:8];
  assign tdiff = $signed({1'b0, in_i.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dsub  = $signed({1'b0, in_i.raw_temperature[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ta_q  <= tdiff * t2;
      s1_dd_q  <= dsub * dsub;
      pr_q[1]  <= PRESS_BASE - {1'b0, in_i.raw_pressure};
      for (int k = 2; k <= 8; k++) pr_q[k] <= pr_q[k-1];
    end
  end

  // Stage 2: first temperature term and the cubic term product.
  logic signed [22:0] s2_ta_q;
  logic signed [38:0] s2_tb_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ta_q <= s1_ta_q[33:11];
      s2_tb_q <= $signed({1'b0, s1_dd_q[33:12]}) * t3;
    end
  end

  // Stage 3: fine temperature.
  logic signed [31:0] s3_tfine_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_tfine_q <= 32'(s2_ta_q) + 32'($signed(s2_tb_q[38:14]));
    end
  end

  // Stage 4: hundredths of a degree, saturated, and the pressure offset.
  logic signed [35:0] tc5;
  logic signed [27:0] tc;
  logic signed [23:0] tc_sat;
  logic signed [32:0] s4_pa_q;
  ptc_side_t          side_q [4:10];
  assign tc5 = 36'(s3_tfine_q) * 36'sd5 + 36'sd128;
  assign tc  = tc5[35:8];
  always_comb begin
    if (tc > TC_MAX) begin
      tc_sat = TC_MAX[23:0];
    end else if (tc < TC_MIN) begin
      tc_sat = TC_MIN[23:0];
    end else begin
      tc_sat = tc[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_pa_q          <= 33'(s3_tfine_q) - TFINE_OFFSET;
      side_q[4].tcent  <= tc_sat;
      side_q[4].tfine  <= s3_tfine_q;
      side_q[4].den_ok <= 1'b0;
      for (int k = 5; k <= 10; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Stage 5: square of the offset and the linear products.
  logic signed [65:0] pa_sq;
  logic [63:0]        s5_aa_q;
  logic signed [48:0] s5_ap5_q, s5_ap2_q;
  assign pa_sq = s4_pa_q * s4_pa_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_aa_q  <= pa_sq[63:0];
      s5_ap5_q <= s4_pa_q * p5;
      s5_ap2_q <= s4_pa_q * p2;
    end
  end

  // Stage 6: partial products of the square with P6 and P3.
  ptc_mul16_t         s6_aa6_q, s6_aa3_q;
  logic signed [48:0] s6_ap5_q, s6_ap2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_aa6_q <= mul16_part(s5_aa_q, 17'(p6));
      s6_aa3_q <= mul16_part(s5_aa_q, 17'(p3));
      s6_ap5_q <= s5_ap5_q;
      s6_ap2_q <= s5_ap2_q;
    end
  end

  // Stage 7: numerator offset term and the biased divisor term.
  logic [63:0] aa3_sum, t3v;
  logic [63:0] s7_b1_q, s7_a2_q;
  assign aa3_sum = mul16_sum(s6_aa3_q);
  assign t3v     = 64'($signed(aa3_sum) >>> 8) + (64'(s6_ap2_q) << 12);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_b1_q <= mul16_sum(s6_aa6_q) + (64'(s6_ap5_q) << 17) + (64'(p4) << 35);
      s7_a2_q <= P1_BIAS + t3v;
    end
  end

  // Stage 8: partial products with P1.
  ptc_mul16_t  s8_a2p1_q;
  logic [63:0] s8_b1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_a2p1_q <= mul16_part(s7_a2_q, $signed({1'b0, p1}));
      s8_b1_q   <= s7_b1_q;
    end
  end

  // Stage 9: divisor and the unscaled numerator.
  logic [63:0]             a2p1_sum;
  logic signed [DEN_W-1:0] s9_den_q;
  logic [63:0]             s9_nump_q;
  assign a2p1_sum = mul16_sum(s8_a2p1_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_den_q  <= a2p1_sum[63:33];
      s9_nump_q <= {12'd0, pr_q[8], 31'd0} - s8_b1_q;
    end
  end

  // Stage 10: numerator scale partial products.
  ptc_mul16_t              s10_np_q;
  logic signed [DEN_W-1:0] s10_den_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_np_q  <= mul16_part(s9_nump_q, PRESS_SCALE);
      s10_den_q <= s9_den_q;
    end
  end

  // Stage 11: signs and magnitudes for the divider.
  logic [63:0]      num;
  logic [63:0]      s11_num_abs_q;
  logic [DEN_W-1:0] s11_den_abs_q;
  logic             s11_neg_q;
  ptc_side_t        s11_side_q;
  assign num = mul16_sum(s10_np_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s11_num_abs_q <= num[63] ? (64'd0 - num) : num;
      s11_den_abs_q <= s10_den_q[DEN_W-1] ? (DEN_W'(0) - s10_den_q) : s10_den_q;
      s11_neg_q     <= num[63] ^ s10_den_q[DEN_W-1];
      s11_side_q    <= '{tcent: side_q[10].tcent, tfine: side_q[10].tfine,
                         den_ok: (s10_den_q != '0)};
    end
  end

  // Stage 1 to 11 valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= '0;
    end else if (adv) begin
      pre_v_q <= {pre_v_q[9:0], in_i.valid};
    end
  end

  // Signed division, one quotient bit per stage.
  logic        div_v;
  logic [63:0] div_q;
  ptc_side_t   div_side;
  ptc_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (pre_v_q[10]),
    .num_abs_i(s11_num_abs_q),
    .den_abs_i(s11_den_abs_q),
    .neg_i    (s11_neg_q),
    .side_i   (s11_side_q),
    .valid_o  (div_v),
    .quot_o   (div_q),
    .side_o   (div_side)
  );

  ptc_side_t   pside_q [0:4];
  logic [63:0] q0_q, q1_q, q2_q, q3_q;

  // Closing stage Q: quotient register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      q0_q       <= div_q;
      pside_q[0] <= div_side;
      for (int k = 1; k <= 4; k++) pside_q[k] <= pside_q[k-1];
    end
  end

  // Closing stage 1: partial products of the squared shifted quotient and of P8.
  logic [63:0] q_sh13;
  ptc_sq_t     c1_xx_q;
  ptc_mul16_t  c1_q8_q;
  assign q_sh13 = 64'($signed(q0_q) >>> 13);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_xx_q <= sq_part(q_sh13);
      c1_q8_q <= mul16_part(q0_q, 17'(p8));
      q1_q    <= q0_q;
    end
  end

  // Closing stage 2: sums of those products.
  logic [63:0] q8_sum;
  logic [63:0] c2_xx_q, c2_b_q;
  assign q8_sum = mul16_sum(c1_q8_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_xx_q <= sq_sum(c1_xx_q);
      c2_b_q  <= 64'($signed(q8_sum) >>> 19);
      q2_q    <= q1_q;
    end
  end

  // Closing stage 3: partial products with P9.
  ptc_mul16_t  c3_x9_q;
  logic [63:0] c3_b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c3_x9_q <= mul16_part(c2_xx_q, 17'(p9));
      c3_b_q  <= c2_b_q;
      q3_q    <= q2_q;
    end
  end

  // Closing stage 4: final pressure before clamping.
  logic [63:0] x9_sum, a9, psum;
  logic [63:0] c4_p_q;
  assign x9_sum = mul16_sum(c3_x9_q);
  assign a9     = 64'($signed(x9_sum) >>> 25);
  assign psum   = q3_q + a9 + c3_b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c4_p_q <= 64'($signed(psum) >>> 8) + (64'(p7) << 4);
    end
  end

  // Output register: clamp to the unsigned 32-bit range, or zero when the divisor was zero.
  logic [31:0]        pclamp;
  logic signed [23:0] out_tc_q;
  logic signed [31:0] out_tf_q;
  logic [31:0]        out_p_q;
  logic               out_pv_q;
  always_comb begin
    if (!pside_q[4].den_ok || c4_p_q[63]) begin
      pclamp = '0;
    end else if (c4_p_q[62:32] != '0) begin
      pclamp = '1;
    end else begin
      pclamp = c4_p_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_tc_q <= pside_q[4].tcent;
      out_tf_q <= pside_q[4].tfine;
      out_p_q  <= pclamp;
      out_pv_q <= pside_q[4].den_ok;
    end
  end

  // Closing stage valid bits and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_v_q <= '0;
      out_v_q  <= 1'b0;
    end else if (adv) begin
      post_v_q <= {post_v_q[4:0], div_v};
      out_v_q  <= post_v_q[4];
    end
  end

  assign out_o.valid             = out_v_q;
  assign out_o.temperature_centi = out_tc_q;
  assign out_o.fine_temperature  = out_tf_q;
  assign out_o.pressure_q24_8    = out_p_q;
  assign out_o.pressure_valid    = out_pv_q;

  // An invalid pressure always reads as zero.
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_pv_q |-> out_p_q == '0) else $error("invalid pressure not zero");
  // A stall freezes the valid bits of every stage.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(pre_v_q) && $stable(post_v_q) && $stable(out_v_q))
    else $error("pipeline moved while stalled");
  // An accepted item enters the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> pre_v_q[0]) else $error("accepted item lost");

endmodule
